// ===== src/ft12_pkg.sv =====
// Shared constants and types for the FT1.2 frame receiver.
package ft12_pkg;

    localparam logic [7:0] START_FIXED = 8'h10;
    localparam logic [7:0] START_VAR   = 8'h68;
    localparam logic [7:0] END_BYTE    = 8'h16;
    localparam logic [8:0] VAR_EXTRA   = 9'd6;

    localparam int IndexWidth = 9;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_ADDRESS  = 3'd2;
    localparam logic [2:0] ST_BAD_END  = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;

    localparam logic KIND_FIXED = 1'b0;
    localparam logic KIND_VAR   = 1'b1;

    typedef struct packed {
        logic [7:0]            frame_byte;
        logic [IndexWidth-1:0] byte_index;
        logic                  frame_last;
        logic                  frame_kind;
        logic [2:0]            frame_status;
    } result_t;

endpackage

// ===== src/ft12_rx_if.sv =====
// Channel that carries received serial bytes.
interface ft12_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ft12_frame_if.sv =====
// Channel that carries frame bytes with index, end mark and status.
interface ft12_frame_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       frame_byte;
    logic [ft12_pkg::IndexWidth-1:0]  byte_index;
    logic                             frame_last;
    logic                             frame_kind;
    logic [2:0]                       frame_status;

    modport source (output valid, output frame_byte, output byte_index, output frame_last,
                    output frame_kind, output frame_status, input ready);
    modport sink (input valid, input frame_byte, input byte_index, input frame_last,
                  input frame_kind, input frame_status, output ready);
endinterface

// ===== src/ft12_frame_receiver.sv =====
// Top level of the FT1.2 frame receiver.
// A byte passes through the input register, then the result register, to the frame channel.
// Throughput: one byte per cycle; the input register empties whenever the result
// register is empty or being transferred in the same cycle.
// Bytes dropped while hunting leave no result but still pass through the input register.
// Reset (rst_n low, asynchronous) empties both registers, returns to hunting and
// clears the station address to zero.
module ft12_frame_receiver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    ft12_rx_if.sink             rx,
    ft12_frame_if.source        frame
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              advance;
    logic              res_valid;
    ft12_pkg::result_t res;
    logic              out_valid;
    ft12_pkg::result_t out_data;

    // move the held byte on when the result register is free or emptying
    assign advance = held_valid && (!out_valid || frame.ready);

    ft12_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    ft12_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .rx_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ft12_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_valid (res_valid),
        .load_data  (res),
        .out_ready  (frame.ready),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    assign frame.valid        = out_valid;
    assign frame.frame_byte   = out_data.frame_byte;
    assign frame.byte_index   = out_data.byte_index;
    assign frame.frame_last   = out_data.frame_last;
    assign frame.frame_kind   = out_data.frame_kind;
    assign frame.frame_status = out_data.frame_status;

endmodule

// ===== src/ft12_input_stage.sv =====
// Input register that captures one received byte.
module ft12_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== src/ft12_parser.sv =====
// Frame parser: hunt state, position, length and checksum tracking per byte.
module ft12_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output ft12_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FIXED,
        PH_VAR
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [ft12_pkg::IndexWidth-1:0] position_reg;
    logic [ft12_pkg::IndexWidth-1:0] position_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       kind_reg;
    logic       kind_next;
    logic       mismatch_reg;
    logic       mismatch_next;
    logic [7:0] station_reg;
    logic [7:0] station_next;
    logic       last;
    logic [2:0] status;
    logic [9:0] pos_wide;
    logic [9:0] sum_end;
    logic       is_start;
    logic [2:0] end_status;

    assign pos_wide   = {1'b0, position_reg};
    assign sum_end    = {2'b00, length_reg} + 10'd3;
    assign is_start   = (rx_byte == ft12_pkg::START_FIXED) || (rx_byte == ft12_pkg::START_VAR);
    assign end_status = (rx_byte != ft12_pkg::END_BYTE) ? ft12_pkg::ST_BAD_END :
                        (mismatch_reg ? ft12_pkg::ST_CHECKSUM : ft12_pkg::ST_OK);
    assign station_next = cfg_we ? cfg_wdata : station_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg + 9'd1;
        length_next   = length_reg;
        sum_next      = sum_reg;
        kind_next     = kind_reg;
        mismatch_next = mismatch_reg;
        last          = 1'b0;
        status        = ft12_pkg::ST_OK;
        res_valid     = 1'b1;

        case (phase_reg)
            PH_HUNT:
            begin
                res_valid     = is_start;
                position_next = '0;
                if (is_start)
                begin
                    kind_next     = (rx_byte == ft12_pkg::START_VAR);
                    phase_next    = kind_next ? PH_VAR : PH_FIXED;
                    position_next = {{(ft12_pkg::IndexWidth-1){1'b0}}, 1'b1};
                    length_next   = '0;
                    sum_next      = '0;
                    mismatch_next = 1'b0;
                end
            end
            PH_FIXED:
            begin
                if (position_reg == 9'd1 || position_reg == 9'd2)
                begin
                    sum_next = sum_reg + rx_byte;
                end
                else if (position_reg == 9'd3)
                begin
                    mismatch_next = (rx_byte != sum_reg);
                end
                else
                begin
                    last   = 1'b1;
                    status = end_status;
                end
            end
            PH_VAR:
            begin
                if (position_reg == 9'd1)
                begin
                    length_next = rx_byte;
                    if (rx_byte < 8'd2)
                    begin
                        last   = 1'b1;
                        status = ft12_pkg::ST_HEADER;
                    end
                end
                else if (position_reg == 9'd2)
                begin
                    if (rx_byte != length_reg)
                    begin
                        last   = 1'b1;
                        status = ft12_pkg::ST_HEADER;
                    end
                end
                else if (position_reg == 9'd3)
                begin
                    if (rx_byte != ft12_pkg::START_VAR)
                    begin
                        last   = 1'b1;
                        status = ft12_pkg::ST_HEADER;
                    end
                end
                else if (pos_wide <= sum_end)
                begin
                    sum_next = sum_reg + rx_byte;
                    if (position_reg == 9'd5 && rx_byte != station_reg)
                    begin
                        last   = 1'b1;
                        status = ft12_pkg::ST_ADDRESS;
                    end
                end
                else if (pos_wide == sum_end + 10'd1)
                begin
                    mismatch_next = (rx_byte != sum_reg);
                end
                else
                begin
                    last   = 1'b1;
                    status = end_status;
                end
            end
            default:
            begin
                res_valid     = 1'b0;
                phase_next    = PH_HUNT;
                position_next = '0;
            end
        endcase

        // drop back to hunting after the closing byte of a frame
        if (last)
        begin
            phase_next    = PH_HUNT;
            position_next = '0;
            length_next   = '0;
            sum_next      = '0;
            kind_next     = 1'b0;
            mismatch_next = 1'b0;
        end

        res.frame_byte   = rx_byte;
        res.byte_index   = (phase_reg == PH_HUNT) ? '0 : position_reg;
        res.frame_last   = last;
        res.frame_kind   = (phase_reg == PH_HUNT) ? (rx_byte == ft12_pkg::START_VAR) : kind_reg;
        res.frame_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            position_reg <= '0;
            length_reg   <= '0;
            sum_reg      <= '0;
            kind_reg     <= ft12_pkg::KIND_FIXED;
            mismatch_reg <= 1'b0;
            station_reg  <= '0;
        end
        else
        begin
            station_reg <= station_next;
            if (step)
            begin
                phase_reg    <= phase_next;
                position_reg <= position_next;
                length_reg   <= length_next;
                sum_reg      <= sum_next;
                kind_reg     <= kind_next;
                mismatch_reg <= mismatch_next;
            end
        end
    end

endmodule

// ===== src/ft12_output_stage.sv =====
// Result register that holds one frame byte until it is transferred.
module ft12_output_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              load_valid,
    input  ft12_pkg::result_t load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output ft12_pkg::result_t out_data
);

    logic              valid_reg;
    logic              valid_next;
    ft12_pkg::result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = load_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/ft12_checker.sv =====
// Port-level checks on the frame channel, bound to the top level.
module ft12_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] frame_byte,
    input logic [8:0] byte_index,
    input logic       frame_last,
    input logic       frame_kind,
    input logic [2:0] frame_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(frame_byte) && $stable(byte_index)
            && $stable(frame_last) && $stable(frame_status))
        else $error("stalled frame byte changed");

    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frame_last |-> frame_status == ft12_pkg::ST_OK)
        else $error("status set on a byte that does not close the frame");

    a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
        valid && byte_index == 9'd0 |->
            !frame_last && ((frame_byte == ft12_pkg::START_FIXED && !frame_kind)
            || (frame_byte == ft12_pkg::START_VAR && frame_kind)))
        else $error("frame opened by a byte that is not its start byte");

    a_fixed_length: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frame_kind |-> byte_index <= 9'd4 && (frame_last == (byte_index == 9'd4)))
        else $error("fixed frame byte out of place");

endmodule

bind ft12_frame_receiver ft12_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (frame.valid),
    .ready        (frame.ready),
    .frame_byte   (frame.frame_byte),
    .byte_index   (frame.byte_index),
    .frame_last   (frame.frame_last),
    .frame_kind   (frame.frame_kind),
    .frame_status (frame.frame_status)
);
